@@ hdl/sctu_pkg.sv @@
// Shared types and constants for the shell command tokenizer.
// Holds the input and result word layouts, token kinds and character codes.
// No dependencies.
package sctu_pkg;

	localparam int LINE_SIZE_DEF   = 1024;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int KIND_W = 3;
	localparam int TOFF_W = 10;
	localparam int TLEN_W = 11;
	localparam int TOFF_MAX = 1023;
	localparam int TLEN_MAX = 1024;

	localparam logic [KIND_W-1:0] KIND_CMD     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ARG     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INPUT   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HEREDOC = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRUNC   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_PIPE    = 3'd6;

	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_SINGLE = 2'd1;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

	localparam logic [1:0] REDIR_NONE = 2'd0;
	localparam logic [1:0] REDIR_LT   = 2'd1;
	localparam logic [1:0] REDIR_GT   = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} char_word_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [TOFF_W-1:0] token_offset;
		logic [TLEN_W-1:0] token_length;
		logic              run_last;
		logic              line_done;
	} token_word_t;

	// Everything one character produces: one or two tokens.
	typedef struct packed {
		logic        two;
		token_word_t first;
		token_word_t second;
	} token_pair_t;

endpackage

@@ hdl/sctu_front.sv @@
// Front part of the tokenizer: takes one character per accepted word, keeps
// the line state and forms the tokens that the character completes.
// Depends on sctu_pkg.
module sctu_front #(
	parameter int LINE_SIZE = sctu_pkg::LINE_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  sctu_pkg::char_word_t item,
	output logic                 pair_valid,
	output sctu_pkg::token_pair_t pair
);

	localparam int POS_W = $clog2(LINE_SIZE + 1);
	localparam int OFF_W = $clog2(LINE_SIZE);

	logic [POS_W-1:0] pos_q;
	logic             in_word_q;
	logic [1:0]       quote_q;
	logic [OFF_W-1:0] start_q;
	logic [1:0]       redir_q;
	logic             cmd_q;

	logic [POS_W-1:0] pos_d;
	logic             in_word_d;
	logic [1:0]       quote_d;
	logic [OFF_W-1:0] start_d;
	logic [1:0]       redir_d;
	logic             cmd_d;

	sctu_pkg::token_word_t r0, r1, tok;
	logic [1:0]       cnt;
	logic [OFF_W-1:0] off;
	logic [POS_W-1:0] len_w;
	logic             used, is_op, is_blank;
	logic [7:0]       c;

	// Clamp offset and length into the fixed result field ranges.
	function automatic sctu_pkg::token_word_t mk_tok(input logic [2:0] kind,
			input logic [OFF_W-1:0] o, input logic [POS_W-1:0] l);
		sctu_pkg::token_word_t t;
		logic [31:0] o32, l32;
		o32 = 32'(o);
		l32 = 32'(l);
		if (o32 > 32'(sctu_pkg::TOFF_MAX)) o32 = 32'(sctu_pkg::TOFF_MAX);
		if (l32 < 32'd1) l32 = 32'd1;
		if (l32 > 32'(sctu_pkg::TLEN_MAX)) l32 = 32'(sctu_pkg::TLEN_MAX);
		t.token_kind   = kind;
		t.token_offset = o32[sctu_pkg::TOFF_W-1:0];
		t.token_length = l32[sctu_pkg::TLEN_W-1:0];
		t.run_last     = 1'b0;
		t.line_done    = 1'b0;
		return t;
	endfunction

	always_comb begin
		c         = item.char_code;
		pos_d     = pos_q;
		in_word_d = in_word_q;
		quote_d   = quote_q;
		start_d   = start_q;
		redir_d   = redir_q;
		cmd_d     = cmd_q;
		r0        = '0;
		r1        = '0;
		tok       = '0;
		cnt       = 2'd0;
		used      = 1'b0;
		len_w     = '0;
		off       = (pos_q < POS_W'(LINE_SIZE)) ? pos_q[OFF_W-1:0] : OFF_W'(LINE_SIZE - 1);
		is_op     = (c == sctu_pkg::CH_LT) || (c == sctu_pkg::CH_GT) || (c == sctu_pkg::CH_BAR);
		is_blank  = (c == sctu_pkg::CH_SPACE) || ((c >= sctu_pkg::CH_TAB) && (c <= sctu_pkg::CH_CR));

		// A waiting < or > is either doubled by this character or flushed alone.
		if (redir_q != sctu_pkg::REDIR_NONE) begin
			if ((redir_q == sctu_pkg::REDIR_LT && c == sctu_pkg::CH_LT) ||
					(redir_q == sctu_pkg::REDIR_GT && c == sctu_pkg::CH_GT)) begin
				tok = mk_tok((redir_q == sctu_pkg::REDIR_LT) ? sctu_pkg::KIND_HEREDOC :
					sctu_pkg::KIND_APPEND, start_q, POS_W'(2));
				used = 1'b1;
			end else begin
				tok = mk_tok((redir_q == sctu_pkg::REDIR_LT) ? sctu_pkg::KIND_INPUT :
					sctu_pkg::KIND_TRUNC, start_q, POS_W'(1));
			end
			r0      = tok;
			cnt     = 2'd1;
			redir_d = sctu_pkg::REDIR_NONE;
			cmd_d   = 1'b0;
		end

		if (!used) begin
			if (in_word_q && quote_q != sctu_pkg::QUOTE_NONE) begin
				if ((quote_q == sctu_pkg::QUOTE_SINGLE && c == sctu_pkg::CH_SQUOTE) ||
						(quote_q == sctu_pkg::QUOTE_DOUBLE && c == sctu_pkg::CH_DQUOTE))
					quote_d = sctu_pkg::QUOTE_NONE;
			end else if (in_word_q && !is_blank && !is_op) begin
				if (c == sctu_pkg::CH_SQUOTE) quote_d = sctu_pkg::QUOTE_SINGLE;
				else if (c == sctu_pkg::CH_DQUOTE) quote_d = sctu_pkg::QUOTE_DOUBLE;
			end else begin
				if (in_word_q) begin
					len_w = (pos_q > POS_W'(start_q)) ? pos_q - POS_W'(start_q) : POS_W'(1);
					tok = mk_tok(cmd_d ? sctu_pkg::KIND_CMD : sctu_pkg::KIND_ARG, start_q, len_w);
					if (cnt == 2'd0) r0 = tok; else r1 = tok;
					cnt       = cnt + 2'd1;
					cmd_d     = 1'b0;
					in_word_d = 1'b0;
					quote_d   = sctu_pkg::QUOTE_NONE;
				end
				if (c == sctu_pkg::CH_BAR) begin
					tok = mk_tok(sctu_pkg::KIND_PIPE, off, POS_W'(1));
					if (cnt == 2'd0) r0 = tok; else r1 = tok;
					cnt   = cnt + 2'd1;
					cmd_d = 1'b1;
				end else if (c == sctu_pkg::CH_LT || c == sctu_pkg::CH_GT) begin
					redir_d = (c == sctu_pkg::CH_LT) ? sctu_pkg::REDIR_LT : sctu_pkg::REDIR_GT;
					start_d = off;
				end else if (!is_blank) begin
					in_word_d = 1'b1;
					start_d   = off;
					quote_d   = (c == sctu_pkg::CH_SQUOTE) ? sctu_pkg::QUOTE_SINGLE :
						((c == sctu_pkg::CH_DQUOTE) ? sctu_pkg::QUOTE_DOUBLE : sctu_pkg::QUOTE_NONE);
				end
			end
		end

		pos_d = (pos_q < POS_W'(LINE_SIZE)) ? pos_q + POS_W'(1) : POS_W'(LINE_SIZE);

		// At the line end, close whatever is open and return to the reset state.
		if (item.line_end) begin
			if (in_word_d) begin
				len_w = (pos_d > POS_W'(start_d)) ? pos_d - POS_W'(start_d) : POS_W'(1);
				tok = mk_tok(cmd_d ? sctu_pkg::KIND_CMD : sctu_pkg::KIND_ARG, start_d, len_w);
				if (cnt == 2'd0) r0 = tok; else r1 = tok;
				cnt = cnt + 2'd1;
			end
			if (redir_d != sctu_pkg::REDIR_NONE) begin
				tok = mk_tok((redir_d == sctu_pkg::REDIR_LT) ? sctu_pkg::KIND_INPUT :
					sctu_pkg::KIND_TRUNC, start_d, POS_W'(1));
				if (cnt == 2'd0) r0 = tok; else r1 = tok;
				cnt = cnt + 2'd1;
			end
			pos_d     = '0;
			in_word_d = 1'b0;
			quote_d   = sctu_pkg::QUOTE_NONE;
			start_d   = '0;
			redir_d   = sctu_pkg::REDIR_NONE;
			cmd_d     = 1'b1;
		end

		if (cnt == 2'd1) begin
			r0.run_last  = 1'b1;
			r0.line_done = item.line_end;
		end else if (cnt == 2'd2) begin
			r1.run_last  = 1'b1;
			r1.line_done = item.line_end;
		end
	end

	assign pair_valid  = accept && (cnt != 2'd0);
	assign pair.two    = (cnt == 2'd2);
	assign pair.first  = r0;
	assign pair.second = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			in_word_q <= 1'b0;
			quote_q   <= sctu_pkg::QUOTE_NONE;
			start_q   <= '0;
			redir_q   <= sctu_pkg::REDIR_NONE;
			cmd_q     <= 1'b1;
		end else if (accept) begin
			pos_q     <= pos_d;
			in_word_q <= in_word_d;
			quote_q   <= quote_d;
			start_q   <= start_d;
			redir_q   <= redir_d;
			cmd_q     <= cmd_d;
		end
	end

endmodule

@@ hdl/sctu_pair_queue.sv @@
// Short queue of token pairs between the front and back parts.
// Depends on sctu_pkg.
module sctu_pair_queue #(
	parameter int DEPTH = sctu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  sctu_pkg::token_pair_t wr_data,
	input  logic                  rd_en,
	output sctu_pkg::token_pair_t rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sctu_pkg::token_pair_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/sctu_back.sv @@
// Back part of the tokenizer: holds one token pair in an output register and
// hands its tokens out one word at a time. Depends on sctu_pkg.
module sctu_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  sctu_pkg::token_pair_t q_data,
	output logic                  q_pop,
	input  logic                  pop,
	output logic                  empty,
	output sctu_pkg::token_word_t token
);

	sctu_pkg::token_pair_t pair_q;
	logic valid_q;
	logic sel_q;
	logic done;

	// The held pair is finished when its last token is taken.
	assign done  = valid_q && pop && (sel_q || !pair_q.two);
	assign q_pop = !q_empty && (!valid_q || done);
	assign empty = !valid_q;
	assign token = sel_q ? pair_q.second : pair_q.first;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pair_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			sel_q   <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (valid_q && pop) begin
			sel_q <= 1'b1;
		end
	end

endmodule

@@ hdl/shell_command_tokenizer_unit.sv @@
// Top level of the shell command tokenizer.
// Instantiates sctu_front, sctu_pair_queue and sctu_back; uses sctu_pkg.
//
// Usage: the input side is a queue port. Each word carries one character of a
// command line and a flag on the line's final character; it is taken at a
// rising edge with push high and full low. The result side is also a queue
// port: while empty is low the oldest token descriptor (kind, offset, length,
// run_last, line_done) sits on token, and pop takes it.
// The front keeps the line state and turns each character into zero, one or
// two tokens in the cycle it is accepted. Those land in a small pair queue,
// and the back part loads each pair into an output register, from which pop
// takes one token per cycle. A completed token is written into the pair queue
// and then moved into the output register, where it sits on token.
// One character is taken per cycle while full is low, the receiver pops every
// cycle and each produces at most one token; the output register hands out one
// token per pop, so characters that each close two tokens are paced by pops.
// When the receiver stalls, the queue fills (QUEUE_DEPTH pairs plus the
// output register) and full rises; nothing is dropped.
// Reset clears the line state to the start of a new line and empties the
// queue and the output register; it needs no clearing pass.
module shell_command_tokenizer_unit #(
	parameter int LINE_SIZE   = sctu_pkg::LINE_SIZE_DEF,
	parameter int QUEUE_DEPTH = sctu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  sctu_pkg::char_word_t  item,
	output logic                  empty,
	input  logic                  pop,
	output sctu_pkg::token_word_t token
);

	logic                  accept;
	logic                  pair_valid;
	sctu_pkg::token_pair_t pair;
	logic                  q_pop, q_empty;
	sctu_pkg::token_pair_t q_data;

	assign accept = push && !full;

	sctu_front #(
		.LINE_SIZE(LINE_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.pair_valid(pair_valid),
		.pair      (pair)
	);

	sctu_pair_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (pair_valid),
		.wr_data(pair),
		.rd_en  (q_pop),
		.rd_data(q_data),
		.full   (full),
		.empty  (q_empty)
	);

	sctu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_data (q_data),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.token  (token)
	);

endmodule
